/* rtl/bppc_pkg.sv */
package bppc_pkg;

  // Widths of the request and result fields.
  localparam int FIELD_W = 9;
  localparam int WAYS_W  = 49;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [WAYS_W-1:0]  ways_t;

endpackage

/* rtl/bppc_if.sv */
interface bppc_in_if;
  import bppc_pkg::*;

  logic   valid;
  logic   ready;
  field_t amount;
  field_t min_part;
  field_t max_part;

  modport source (output valid, output amount, output min_part, output max_part,
                  input ready);
  modport sink   (input valid, input amount, input min_part, input max_part,
                  output ready);
endinterface

interface bppc_out_if;
  import bppc_pkg::*;

  logic  valid;
  logic  ready;
  ways_t ways;

  modport source (output valid, output ways, input ready);
  modport sink   (input valid, input ways, output ready);
endinterface

/* rtl/bppc_mem.sv */
module bppc_mem
  import bppc_pkg::*;
#(
  parameter int DEPTH = 257,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  ways_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output ways_t         rdata_a,
  output ways_t         rdata_b
);

  ways_t mem [DEPTH];
  ways_t q_a_r;
  ways_t q_b_r;
  ways_t fwd_data_r;
  logic  hit_a_r;
  logic  hit_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write to the same entry in the same cycle takes the
  // new data through the bypass register.
  always_ff @(posedge clk) begin
    if (re) begin
      q_a_r   <= mem[raddr_a];
      q_b_r   <= mem[raddr_b];
      hit_a_r <= we && (waddr == raddr_a);
      hit_b_r <= we && (waddr == raddr_b);
    end
    fwd_data_r <= wdata;
  end

  assign rdata_a = hit_a_r ? fwd_data_r : q_a_r;
  assign rdata_b = hit_b_r ? fwd_data_r : q_b_r;

endmodule

/* rtl/bounded_part_partition_count.sv */
// A request first initialises table entries 0 to a, where a is the clamped amount, then for
// each part size p = 1..P, with P = min(max_part, a), sweeps entries p to a. Trivial
// requests (a zero amount or an empty range) skip the table.
// Throughput: one request at a time; the table memory does one read-add-write per cycle.
// Reset (rst_n, synchronous, active low) clears the sequencer, the result valid flag and
// the lower-cut snapshot; the table memory is not cleared and needs no clearing pass.
module bounded_part_partition_count
  import bppc_pkg::*;
#(
  parameter int MAX_N = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  bppc_in_if.sink     in_req,
  bppc_out_if.source  out_res
);

  localparam int AW = $clog2(MAX_N + 1);
  localparam int EW = FIELD_W + 1;
  localparam logic [EW-1:0] MAXN_C = EW'(MAX_N);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state_r;
  logic [AW-1:0] amt_r;
  logic [AW-1:0] hi_r;
  logic [AW-1:0] cut_r;
  logic [AW-1:0] pmax_r;
  logic          lo_gt_r;
  logic [AW-1:0] p_r;
  logic [AW-1:0] t_r;
  logic          s1_v_r;
  logic [AW-1:0] s1_t_r;
  logic          s1_last_r;
  logic          s1_snap_r;
  ways_t         low_cut_r;
  ways_t         ways_r;
  logic          out_valid_r;
  ways_t         out_ways_r;

  // Clamping of the request fields. Everything is compared one bit wider than the
  // fields so that MAX_N never truncates.
  logic [EW-1:0] amt_ext;
  logic [EW-1:0] hi_ext;
  logic [EW-1:0] lo_ext;
  logic [AW-1:0] amt_c;
  logic [AW-1:0] hi_c;
  logic          lo_gt_c;
  logic [AW-1:0] cut_c;
  logic          accept;

  assign accept  = in_req.valid && in_req.ready;
  assign amt_ext = {1'b0, in_req.amount};
  assign hi_ext  = {1'b0, in_req.max_part};
  assign lo_ext  = (in_req.min_part == '0) ? EW'(1) : {1'b0, in_req.min_part};
  assign amt_c   = (amt_ext > MAXN_C) ? AW'(MAX_N) : AW'(amt_ext);
  assign hi_c    = (hi_ext > MAXN_C) ? AW'(MAX_N) : AW'(hi_ext);
  assign lo_gt_c = lo_ext > EW'(hi_c);
  // The cut is one below the lower bound; it only matters when it lies below hi.
  assign cut_c   = AW'(lo_ext - EW'(1));

  // Table memory: entry t holds the number of partitions of t using the part sizes
  // processed so far. Port A reads entry t, port B reads entry t - p.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  ways_t         mem_wdata;
  logic          mem_re;
  ways_t         rd_a;
  ways_t         rd_b;
  ways_t         sum;

  assign sum       = rd_a + rd_b;
  assign mem_re    = (state_r == S_RUN);
  assign mem_we    = (state_r == S_INIT) || s1_v_r;
  assign mem_waddr = s1_v_r ? s1_t_r : t_r;
  assign mem_wdata = s1_v_r ? sum : ((t_r == '0) ? WAYS_W'(1) : '0);

  bppc_mem #(
    .DEPTH (MAX_N + 1),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (t_r),
    .raddr_b (t_r - p_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // The final count is the table value at the amount after the last part size, less
  // the snapshot at the lower cut. When the snapshot is taken by the same write, the
  // new sum is used in place of the register.
  ways_t low_eff;
  assign low_eff = s1_snap_r ? sum : low_cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      low_cut_r   <= '0;
    end else begin
      s1_v_r <= (state_r == S_RUN);

      // In the final step the result register is reloaded below instead.
      if (out_valid_r && out_res.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      // Write-back side of the read-add-write pipeline.
      if (s1_v_r) begin
        if (s1_snap_r) begin
          low_cut_r <= sum;
        end
        if (s1_last_r) begin
          ways_r <= sum - low_eff;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            amt_r   <= amt_c;
            hi_r    <= hi_c;
            lo_gt_r <= lo_gt_c;
            cut_r   <= cut_c;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (amt_r == '0) begin
            ways_r  <= WAYS_W'(1);
            state_r <= S_FIN;
          end else if (lo_gt_r) begin
            ways_r  <= '0;
            state_r <= S_FIN;
          end else begin
            // Part sizes above the amount leave the table unchanged, so both the
            // last part size and the cut are limited to the amount.
            pmax_r    <= (hi_r < amt_r) ? hi_r : amt_r;
            cut_r     <= (cut_r < amt_r) ? cut_r : amt_r;
            low_cut_r <= '0;
            t_r       <= '0;
            state_r   <= S_INIT;
          end
        end
        S_INIT: begin
          if (t_r == amt_r) begin
            p_r     <= AW'(1);
            t_r     <= AW'(1);
            state_r <= S_RUN;
          end else begin
            t_r <= t_r + AW'(1);
          end
        end
        S_RUN: begin
          s1_t_r    <= t_r;
          s1_last_r <= (t_r == amt_r) && (p_r == pmax_r);
          s1_snap_r <= (t_r == amt_r) && (p_r == cut_r);
          if (t_r == amt_r) begin
            if (p_r == pmax_r) begin
              state_r <= S_WAIT;
            end else begin
              p_r <= p_r + AW'(1);
              t_r <= p_r + AW'(1);
            end
          end else begin
            t_r <= t_r + AW'(1);
          end
        end
        S_WAIT: begin
          // The last write-back happens in this cycle.
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            out_ways_r  <= ways_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_res.valid = out_valid_r;
  assign out_res.ways  = out_ways_r;

`ifndef NO_ASSERTIONS
  // Every request moves straight into the preparation step.
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_PREP))
    else $error("request accepted without entering preparation");

  // The sweep index stays between the current part size and the amount.
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((t_r >= p_r) && (t_r <= amt_r) && (p_r <= pmax_r)))
    else $error("table sweep index out of range");

  // Write-backs only follow reads issued in the sweep.
  a_wb_origin: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ((state_r == S_RUN) || (state_r == S_WAIT)))
    else $error("write-back outside the sweep");

  // The lower cut never passes the last part size during the sweep.
  a_cut_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cut_r <= pmax_r))
    else $error("lower cut beyond last part size");
`endif

endmodule

/* tb/bounded_part_partition_count_test.sv */
module bounded_part_partition_count_test;
  import bppc_pkg::*;

  // The block is built with its default table size, and the predictor below keeps a
  // table of the same size.
  localparam int PART_LIMIT = 256;

  // Idling phases: none, sender idle, receiver stalling, both.
  localparam int N_PHASES = 4;
  localparam int N_RANDOM = 100;

  // Only the first few errors are described in full, the rest are counted.
  localparam int REPORT_MAX = 10;

  // One queued request with the idling phase it belongs to. A request marked
  // drain_first is held back until every outstanding count has come out of the block.
  typedef struct {
    field_t      amount;
    field_t      min_part;
    field_t      max_part;
    bit          drain_first;
    int unsigned phase;
  } part_query_t;

  logic clk;
  logic rst_n;

  bppc_in_if  in_req ();
  bppc_out_if out_res ();

  bounded_part_partition_count #(
    .MAX_N (PART_LIMIT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // Requests waiting to be driven, and the counts that the block still owes us, oldest
  // first.
  part_query_t query_q[$];
  ways_t       ways_due_q[$];

  int unsigned req_launched;
  int unsigned req_accepts;
  int unsigned fail_count;
  int unsigned recv_phase;
  longint unsigned cycle_limit;

  int unsigned send_idle_pct  [N_PHASES] = '{0, 84, 0, 38};
  int unsigned recv_stall_pct [N_PHASES] = '{0, 0, 84, 38};

  // Private copy of the running-sum table and the lower-cut snapshot.
  ways_t ways_by_amount [0:PART_LIMIT];
  ways_t low_cut_snapshot;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Counts the partitions of the amount whose largest part lies in the requested
  // range. The table is rebuilt part size by part size; once the part size reaches
  // one below the lower bound the running value is saved, and the answer is the final
  // value less that snapshot. All arithmetic wraps at the width of the result field.
  function automatic ways_t predict_ways(field_t amount, field_t min_part,
                                         field_t max_part);
    int unsigned amt;
    int unsigned lo;
    int unsigned hi;
    int unsigned cut;
    amt = (amount > PART_LIMIT) ? PART_LIMIT : amount;
    hi  = (max_part > PART_LIMIT) ? PART_LIMIT : max_part;
    lo  = (min_part == 0) ? 1 : min_part;
    // The empty sum is the one way to make nothing, whatever the bounds say.
    if (amt == 0)
      return ways_t'(1);
    // An empty range, including an upper bound of zero, admits no partition.
    if (lo > hi)
      return ways_t'(0);
    cut = lo - 1;
    ways_by_amount[0] = ways_t'(1);
    for (int t = 1; t <= amt; t++)
      ways_by_amount[t] = '0;
    low_cut_snapshot = (cut == 0) ? ways_by_amount[amt] : ways_t'(0);
    for (int p = 1; p <= hi; p++) begin
      for (int t = p; t <= amt; t++)
        ways_by_amount[t] = ways_by_amount[t] + ways_by_amount[t - p];
      if (p == cut)
        low_cut_snapshot = ways_by_amount[amt];
    end
    return ways_by_amount[amt] - low_cut_snapshot;
  endfunction

  task automatic flag_error(string msg);
    if (fail_count < REPORT_MAX)
      $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Queues one request and widens the time budget by a generous multiple of an
  // estimate of its latency, plus room for idling on either side.
  task automatic add_query(int unsigned amount, int unsigned min_part,
                           int unsigned max_part, int unsigned phase, bit drain_first);
    part_query_t q;
    longint unsigned a;
    longint unsigned pmax;
    longint unsigned est;
    q.amount      = field_t'(amount);
    q.min_part    = field_t'(min_part);
    q.max_part    = field_t'(max_part);
    q.phase       = phase;
    q.drain_first = drain_first;
    query_q.push_back(q);
    a    = (amount > PART_LIMIT) ? PART_LIMIT : amount;
    pmax = (max_part > PART_LIMIT) ? PART_LIMIT : max_part;
    if (pmax > a)
      pmax = a;
    est = (a + 1) + pmax * (a + 1) - (pmax * (pmax + 1)) / 2 + 4;
    cycle_limit += 4 * (est + 64);
  endtask

  // Stimulus and the end of the run.
  initial begin
    int unsigned r;
    int unsigned amt;
    int unsigned ph;
    int unsigned last_ph;

    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.amount   = '0;
    in_req.min_part = '0;
    in_req.max_part = '0;
    out_res.ready   = 1'b0;
    req_launched    = 0;
    req_accepts     = 0;
    fail_count      = 0;
    recv_phase      = 0;
    cycle_limit     = 20000;

    // Directed requests, all in the phase without idling. They cover the empty amount,
    // a lower bound of zero, an empty range, an upper bound of zero, clamping of the
    // amount and of both bounds, and a few of the slowest full-table requests.
    add_query(0,   0,   0,   0, 1'b0);
    add_query(0,   511, 511, 0, 1'b0);
    add_query(1,   1,   1,   0, 1'b0);
    add_query(5,   0,   5,   0, 1'b0);
    add_query(5,   3,   2,   0, 1'b0);
    add_query(5,   1,   0,   0, 1'b0);
    add_query(10,  1,   10,  0, 1'b0);
    add_query(10,  3,   5,   0, 1'b0);
    add_query(10,  10,  10,  0, 1'b0);
    add_query(10,  11,  300, 0, 1'b0);
    add_query(20,  511, 511, 0, 1'b0);
    add_query(20,  256, 300, 0, 1'b0);
    add_query(1,   0,   511, 0, 1'b0);
    add_query(255, 2,   2,   0, 1'b0);
    add_query(300, 2,   3,   0, 1'b0);
    add_query(256, 0,   1,   0, 1'b0);
    add_query(256, 1,   256, 0, 1'b0);
    add_query(511, 1,   511, 0, 1'b0);
    add_query(256, 100, 200, 0, 1'b0);
    add_query(40,  20,  40,  0, 1'b0);

    // Random requests, spread over the idling phases. Most use small amounts so that
    // the table walk stays short; large amounts mostly come with a small upper bound,
    // and only a few walk the whole table. The first request of every phase waits for
    // the block to drain completely.
    last_ph = N_PHASES;
    for (int i = 0; i < N_RANDOM; i++) begin
      ph = (i * N_PHASES) / N_RANDOM;
      r  = $urandom_range(99);
      if (r < 5) begin
        add_query(0, $urandom_range(511), $urandom_range(511), ph, ph != last_ph);
      end else if (r < 65) begin
        amt = $urandom_range(24, 1);
        add_query(amt, $urandom_range(amt + 2), $urandom_range(amt + 4), ph,
                  ph != last_ph);
      end else if (r < 80) begin
        add_query($urandom_range(24, 1), $urandom_range(511), $urandom_range(511), ph,
                  ph != last_ph);
      end else if (r < 96) begin
        add_query($urandom_range(511, 25), $urandom_range(7), $urandom_range(6), ph,
                  ph != last_ph);
      end else begin
        add_query($urandom_range(511, 200), $urandom_range(511), $urandom_range(511),
                  ph, ph != last_ph);
      end
      last_ph = ph;
    end

    // Synchronous reset, released at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every request must be taken and every count must have come back.
    while (query_q.size() != 0 || req_accepts != req_launched || ways_due_q.size() != 0)
      @(posedge clk);
    // A little longer, so that a stray extra result would still be caught.
    repeat (64) @(posedge clk);

    if (fail_count == 0)
      $display("bounded_part_partition_count_test: clean");
    else
      $display("bounded_part_partition_count_test: errors");
    $finish;
  end

  // Request driver. A new request may go out once the previous one has been accepted,
  // which the monitor signals by catching up with the launch count. The sender idles
  // at random according to the phase of the waiting request.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (req_accepts == req_launched) begin
      if (query_q.size() != 0 && !(query_q[0].drain_first && ways_due_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct[query_q[0].phase]) begin
        in_req.valid    <= 1'b1;
        in_req.amount   <= query_q[0].amount;
        in_req.min_part <= query_q[0].min_part;
        in_req.max_part <= query_q[0].max_part;
        recv_phase      <= query_q[0].phase;
        void'(query_q.pop_front());
        req_launched++;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls at random according to the phase of the latest request.
  always @(negedge clk) begin
    if (!rst_n)
      out_res.ready <= 1'b0;
    else
      out_res.ready <= ($urandom_range(99) >= recv_stall_pct[recv_phase]);
  end

  // Monitor. An accepted request has its count predicted straight away; an accepted
  // result is checked against the oldest prediction still owed.
  always @(posedge clk) begin
    ways_t due;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        ways_due_q.push_back(predict_ways(in_req.amount, in_req.min_part,
                                          in_req.max_part));
        req_accepts++;
      end
      if (out_res.valid && out_res.ready) begin
        if (ways_due_q.size() == 0) begin
          flag_error($sformatf("unexpected result: ways %0d", out_res.ways));
        end else begin
          due = ways_due_q.pop_front();
          if (out_res.ways !== due)
            flag_error($sformatf("ways mismatch: expected %0d, got %0d", due,
                                 out_res.ways));
        end
      end
    end
  end

  // Watchdog: the limit was worked out from the queued requests before the clock
  // started.
  initial begin
    longint unsigned cycles;
    cycles = 0;
    @(posedge clk);
    while (cycles < cycle_limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timed out with %0d results outstanding", $realtime,
             ways_due_q.size());
    $display("bounded_part_partition_count_test: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bppc_pkg.sv
rtl/bppc_if.sv
rtl/bppc_mem.sv
rtl/bounded_part_partition_count.sv
tb/bounded_part_partition_count_test.sv
